[src/mcc_pkg.sv]
package mcc_pkg;

   localparam int NUM_PROCS       = 4;
   localparam int LINES_PER_CACHE = 8;
   localparam int MEM_WORDS       = 256;
   localparam int WORD_BITS       = 64;
   localparam int PROC_W          = 2;
   localparam int SLOT_W          = 3;
   localparam int ADDR_W          = 8;
   localparam int IDX_W           = PROC_W + SLOT_W;
   localparam int NLINES          = NUM_PROCS * LINES_PER_CACHE;

   typedef enum logic [1:0] {
      MESI_I = 2'd0,
      MESI_S = 2'd1,
      MESI_E = 2'd2,
      MESI_M = 2'd3
   } mesi_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOK,
      ST_COMMIT,
      ST_EVICT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic capture;
      logic look;
      logic commit;
      logic evict;
      logic load_rsp;
   } ctrl_cmd_type;

   typedef struct packed {
      logic evict_pending;
      logic out_free;
   } dp_status_type;

endpackage

[src/mcc_ctrl.sv]
module mcc_ctrl import mcc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_LOOK;
            end
         end
         ST_LOOK: begin
            cmd.look = 1'b1;
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = status.evict_pending ? ST_EVICT : ST_DONE;
         end
         ST_EVICT: begin
            cmd.evict = 1'b1;
            state_in  = ST_DONE;
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

[src/mcc_datapath.sv]
module mcc_datapath import mcc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  ctrl_cmd_type         cmd,
   output dp_status_type        status,
   input  logic                 req_cmd,
   input  logic [PROC_W-1:0]    req_proc_select,
   input  logic [ADDR_W-1:0]    req_word_address,
   input  logic [WORD_BITS-1:0] req_write_value,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_hit,
   output logic [1:0]           rsp_line_state,
   output logic [SLOT_W-1:0]    rsp_line_slot,
   output logic [WORD_BITS-1:0] rsp_line_value,
   output logic                 rsp_snoop_writeback,
   output logic                 rsp_evict_writeback,
   output logic [ADDR_W-1:0]    rsp_evict_address,
   output logic [NUM_PROCS-1:0] rsp_others_changed
);

   // request
   logic                 is_w_ff;
   logic [PROC_W-1:0]    proc_ff;
   logic [ADDR_W-1:0]    addr_ff;
   logic [WORD_BITS-1:0] wv_ff;

   // line state
   logic [ADDR_W-1:0]    tag_ff  [NLINES];
   mesi_type             mesi_ff [NLINES];
   logic [WORD_BITS-1:0] line_word [NLINES];
   logic [SLOT_W-1:0]    fifo_ff [NUM_PROCS];

   // shared memory
   logic [WORD_BITS-1:0] main_memory [MEM_WORDS];
   logic [MEM_WORDS-1:0] mem_vld_ff;

   // lookup results
   logic                 hit_ff;
   logic [SLOT_W-1:0]    slot_ff;
   mesi_type             own_st_ff;
   logic [NLINES-1:0]    omatch_ff;
   logic [NLINES-1:0]    onots_ff;
   logic                 m_any_ff;
   logic                 ewb_ff;
   logic [ADDR_W-1:0]    vtag_ff;
   logic [WORD_BITS-1:0] rd_a_ff;
   logic [WORD_BITS-1:0] rd_b_ff;
   logic [WORD_BITS-1:0] mem_rd_ff;
   logic                 mem_vld_rd_ff;

   // result
   logic                 res_hit_ff;
   mesi_type             res_state_ff;
   logic [SLOT_W-1:0]    res_slot_ff;
   logic [WORD_BITS-1:0] res_value_ff;
   logic                 res_swb_ff;
   logic                 res_ewb_ff;
   logic [ADDR_W-1:0]    res_eaddr_ff;
   logic [NUM_PROCS-1:0] res_changed_ff;

   logic                 rsp_valid_ff;

   // lookup logic
   logic [NLINES-1:0]    match;
   logic [NLINES-1:0]    own_line;
   logic [NLINES-1:0]    other_match;
   logic [NLINES-1:0]    other_nots;
   logic                 hit;
   logic [SLOT_W-1:0]    own_slot;
   logic                 m_any;
   logic [IDX_W-1:0]     m_idx;
   logic [IDX_W-1:0]     own_idx;
   logic [IDX_W-1:0]     vidx;
   logic [IDX_W-1:0]     rd_a_idx;

   always_comb begin
      hit      = 1'b0;
      own_slot = '0;
      m_any    = 1'b0;
      m_idx    = '0;
      for (int i = 0; i < NLINES; i++) begin
         match[i]       = (mesi_ff[i] != MESI_I) && (tag_ff[i] == addr_ff);
         own_line[i]    = (IDX_W'(i) >> SLOT_W) == IDX_W'(proc_ff);
         other_match[i] = match[i] && !own_line[i];
         other_nots[i]  = mesi_ff[i] != MESI_S;
         if (other_match[i] && (mesi_ff[i] == MESI_M)) begin
            m_any = 1'b1;
            m_idx = IDX_W'(i);
         end
      end
      for (int s = 0; s < LINES_PER_CACHE; s++) begin
         if (match[{proc_ff, SLOT_W'(s)}]) begin
            hit      = 1'b1;
            own_slot = SLOT_W'(s);
         end
      end
      own_idx  = {proc_ff, own_slot};
      vidx     = {proc_ff, fifo_ff[proc_ff]};
      rd_a_idx = hit ? own_idx : m_idx;
   end

   // commit logic
   logic                 inval;
   logic                 snoop;
   logic                 swb;
   logic                 found;
   logic                 upd_own;
   logic [NLINES-1:0]    chg;
   logic [NUM_PROCS-1:0] changed;
   logic [IDX_W-1:0]     cidx;
   mesi_type             new_st;
   logic [WORD_BITS-1:0] mem_word;
   logic [WORD_BITS-1:0] new_value;
   logic [SLOT_W-1:0]    next_ptr;

   always_comb begin
      inval   = is_w_ff && (!hit_ff || (own_st_ff == MESI_S));
      snoop   = !hit_ff || inval;
      swb     = snoop && m_any_ff;
      found   = |omatch_ff;
      upd_own = !hit_ff || is_w_ff;
      cidx    = {proc_ff, slot_ff};
      for (int i = 0; i < NLINES; i++) begin
         chg[i] = snoop && omatch_ff[i] && (inval || onots_ff[i]);
      end
      for (int q = 0; q < NUM_PROCS; q++) begin
         changed[q] = |chg[q*LINES_PER_CACHE +: LINES_PER_CACHE];
      end
      mem_word = mem_vld_rd_ff ? mem_rd_ff : '0;
      if (hit_ff && !is_w_ff) begin
         new_st    = own_st_ff;
         new_value = rd_a_ff;
      end else if (is_w_ff) begin
         new_st    = MESI_M;
         new_value = wv_ff;
      end else begin
         new_st    = found ? MESI_S : MESI_E;
         new_value = m_any_ff ? rd_a_ff : mem_word;
      end
      if (slot_ff == SLOT_W'(LINES_PER_CACHE - 1)) begin
         next_ptr = '0;
      end else begin
         next_ptr = slot_ff + SLOT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         is_w_ff <= req_cmd;
         proc_ff <= req_proc_select;
         addr_ff <= req_word_address;
         wv_ff   <= req_write_value;
      end
      if (cmd.look) begin
         hit_ff        <= hit;
         slot_ff       <= hit ? own_slot : fifo_ff[proc_ff];
         own_st_ff     <= mesi_ff[own_idx];
         omatch_ff     <= other_match;
         onots_ff      <= other_nots;
         m_any_ff      <= m_any;
         ewb_ff        <= !hit && (mesi_ff[vidx] == MESI_M);
         vtag_ff       <= tag_ff[vidx];
         rd_a_ff       <= line_word[rd_a_idx];
         rd_b_ff       <= line_word[vidx];
         mem_rd_ff     <= main_memory[addr_ff];
         mem_vld_rd_ff <= mem_vld_ff[addr_ff];
      end
      if (cmd.commit) begin
         if (upd_own) begin
            tag_ff[cidx]    <= addr_ff;
            line_word[cidx] <= new_value;
         end
         res_hit_ff     <= hit_ff;
         res_state_ff   <= new_st;
         res_slot_ff    <= slot_ff;
         res_value_ff   <= new_value;
         res_swb_ff     <= swb;
         res_ewb_ff     <= ewb_ff;
         res_eaddr_ff   <= ewb_ff ? vtag_ff : '0;
         res_changed_ff <= changed;
      end
      if (cmd.commit && swb) begin
         main_memory[addr_ff] <= rd_a_ff;
      end else if (cmd.evict) begin
         main_memory[vtag_ff] <= rd_b_ff;
      end
      if (cmd.load_rsp) begin
         rsp_hit             <= res_hit_ff;
         rsp_line_state      <= res_state_ff;
         rsp_line_slot       <= res_slot_ff;
         rsp_line_value      <= res_value_ff;
         rsp_snoop_writeback <= res_swb_ff;
         rsp_evict_writeback <= res_ewb_ff;
         rsp_evict_address   <= res_eaddr_ff;
         rsp_others_changed  <= res_changed_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NLINES; i++) begin
            mesi_ff[i] <= MESI_I;
         end
         for (int q = 0; q < NUM_PROCS; q++) begin
            fifo_ff[q] <= '0;
         end
         mem_vld_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.commit) begin
            for (int i = 0; i < NLINES; i++) begin
               if (chg[i]) begin
                  mesi_ff[i] <= inval ? MESI_I : MESI_S;
               end
            end
            if (upd_own) begin
               mesi_ff[cidx] <= new_st;
            end
            if (!hit_ff) begin
               fifo_ff[proc_ff] <= next_ptr;
            end
            if (swb) begin
               mem_vld_ff[addr_ff] <= 1'b1;
            end
         end
         if (cmd.evict) begin
            mem_vld_ff[vtag_ff] <= 1'b1;
         end
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign status.evict_pending = ewb_ff;
   assign status.out_free      = !rsp_valid_ff || !rsp_stall;

endmodule

[src/mesi_coherence_controller_unit.sv]
// MESI coherence unit: four private, fully associative caches of eight one-word
// lines over a shared memory of 256 64-bit words. One access is taken at a time
// and returns one result item. A hit or a miss without a modified victim passes
// through capture, tag lookup with registered line and memory reads, commit and
// result load; a miss that writes back a modified victim adds an evict step for
// the second write on the single memory write port. The next item is accepted in
// the cycle after the result is loaded, while that result may still be waiting
// on rsp_stall.
module mesi_coherence_controller_unit import mcc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_cmd,
   input  logic [PROC_W-1:0]    req_proc_select,
   input  logic [ADDR_W-1:0]    req_word_address,
   input  logic [WORD_BITS-1:0] req_write_value,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_hit,
   output logic [1:0]           rsp_line_state,
   output logic [SLOT_W-1:0]    rsp_line_slot,
   output logic [WORD_BITS-1:0] rsp_line_value,
   output logic                 rsp_snoop_writeback,
   output logic                 rsp_evict_writeback,
   output logic [ADDR_W-1:0]    rsp_evict_address,
   output logic [NUM_PROCS-1:0] rsp_others_changed
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   mcc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   mcc_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_cmd             (req_cmd),
      .req_proc_select     (req_proc_select),
      .req_word_address    (req_word_address),
      .req_write_value     (req_write_value),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_hit             (rsp_hit),
      .rsp_line_state      (rsp_line_state),
      .rsp_line_slot       (rsp_line_slot),
      .rsp_line_value      (rsp_line_value),
      .rsp_snoop_writeback (rsp_snoop_writeback),
      .rsp_evict_writeback (rsp_evict_writeback),
      .rsp_evict_address   (rsp_evict_address),
      .rsp_others_changed  (rsp_others_changed)
   );

endmodule
